// ----- rtl/core/velocity_command_safety_gate_unit_assert.svh -----
// Assertion macros for the velocity command safety gate.
`ifndef VELOCITY_COMMAND_SAFETY_GATE_UNIT_ASSERT_SVH
`define VELOCITY_COMMAND_SAFETY_GATE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle (or after a ## in cons)
`define VCSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcsg: implication check failed");

// condition must never hold outside reset
`define VCSG_ASSERT_NEVER(lbl, clk, rst_n, bad) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error("vcsg: forbidden condition seen");

`endif

// ----- rtl/core/vcsg_pkg.sv -----
// Shared types, register indexes and codes of the velocity command safety gate.
package vcsg_pkg;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MAX_LINEAR_X       = 3'd0;
    localparam t_cfg_idx CFG_MAX_LINEAR_Y       = 3'd1;
    localparam t_cfg_idx CFG_MAX_ANGULAR_Z      = 3'd2;
    localparam t_cfg_idx CFG_SLOWDOWN_FLOOR     = 3'd3;
    localparam t_cfg_idx CFG_SLOWDOWN_CEILING   = 3'd4;
    localparam t_cfg_idx CFG_COMMAND_TIMEOUT_MS = 3'd5;
    localparam t_cfg_idx CFG_MODE_BITS          = 3'd6;

    localparam logic [15:0] Q15_ONE = 16'h8000;

    typedef logic [3:0] t_reason;

    localparam t_reason RSN_ALLOWED    = 4'd0;
    localparam t_reason RSN_RECOVERY   = 4'd1;
    localparam t_reason RSN_SLOW_ZERO  = 4'd2;
    localparam t_reason RSN_NONE       = 4'd3;
    localparam t_reason RSN_STOP_STALE = 4'd4;
    localparam t_reason RSN_SLOW_STALE = 4'd5;
    localparam t_reason RSN_STOP       = 4'd6;
    localparam t_reason RSN_INVALID    = 4'd7;
    localparam t_reason RSN_CMD_STALE  = 4'd8;

    // flag bit positions
    localparam int FL_HAVE_CMD   = 0;
    localparam int FL_CMD_OK     = 1;
    localparam int FL_REC_ASK    = 2;
    localparam int FL_HAVE_REC   = 3;
    localparam int FL_REC_OK     = 4;
    localparam int FL_STOP       = 5;
    localparam int FL_STOP_STALE = 6;
    localparam int FL_SLOW_STALE = 7;
    localparam int FL_HAVE_DEC   = 8;
    localparam int FL_DEC_STOP   = 9;
    localparam int FL_HAVE_OVR   = 10;

    // mode bit positions
    localparam int MD_RECOVERY = 0;
    localparam int MD_FAILSAFE = 1;
    localparam int MD_ZERO     = 2;
    localparam int MD_SLOW_LIN = 3;
    localparam int MD_SLOW_ANG = 4;

    typedef struct packed {
        logic [10:0]        flags;
        logic signed [15:0] cmd_vx;
        logic signed [15:0] cmd_vy;
        logic signed [15:0] cmd_wz;
        logic [15:0]        cmd_age_ms;
        logic signed [15:0] rec_vx;
        logic signed [15:0] rec_vy;
        logic signed [15:0] rec_wz;
        logic [15:0]        rec_age_ms;
        logic [15:0]        decision_slowdown;
        logic [15:0]        override_slowdown;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] out_vx;
        logic signed [15:0] out_vy;
        logic signed [15:0] out_wz;
        logic               allowed;
        logic               stopped;
        logic               stale_flag;
        logic [15:0]        slow_factor;
        t_reason            reason_code;
        logic               from_recovery;
    } t_out_beat;

    typedef struct packed {
        logic [14:0] max_linear_x;
        logic [14:0] max_linear_y;
        logic [14:0] max_angular_z;
        logic [15:0] slowdown_floor;
        logic [15:0] slowdown_ceiling;
        logic [15:0] command_timeout_ms;
        logic [4:0]  mode_bits;
    } t_cfg;

    // how the final stage builds the beat
    typedef enum logic [1:0] {
        KIND_FORCED,
        KIND_RAW,
        KIND_PASS
    } t_kind;

    // after select: lanes 0..2 are x, y, z
    typedef struct packed {
        t_kind            kind;
        t_reason          reason;
        logic             stale;
        logic             use_rec;
        logic [2:0][15:0] vel;
        logic [15:0]      age;
        logic [15:0]      factor;
    } t_s1;

    // after age check, factor limits and pre-clamp
    typedef struct packed {
        t_kind            kind;
        t_reason          reason;
        logic             stale;
        logic             use_rec;
        logic [2:0][15:0] raw;
        logic [2:0][14:0] mag;
        logic [2:0]       neg;
        logic [2:0]       scale_en;
        logic [15:0]      factor;
    } t_s2;

    // after scaling
    typedef struct packed {
        t_kind            kind;
        t_reason          reason;
        logic             stale;
        logic             use_rec;
        logic [2:0][15:0] raw;
        logic [2:0][14:0] mag;
        logic [2:0]       neg;
        logic [15:0]      factor;
    } t_s3;

endpackage

// ----- rtl/core/vcsg_decide.sv -----
// Check priority, command select, slowdown factor and per-axis pre-clamp (two stages).
module vcsg_decide import vcsg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_item,
    input  t_cfg     i_cfg,
    output logic     o_valid,
    output t_s2      o_s2
);

    logic        have_cmd, cmd_ok, rec_ask, have_rec, rec_ok;
    logic        stop_f, stop_stale, slow_stale, have_dec, dec_stop, have_ovr;
    logic        rec_usable, stop_active;
    logic [15:0] f_pick;
    t_s1         n_s1, r_s1;
    logic        r_s1_valid;

    logic        cmd_stale;
    logic [15:0] f_lo, f_hi, f_fin;
    logic [2:0][14:0] lim;
    logic [2:0][15:0] abs_v;
    t_s2         n_s2, r_s2;
    logic        r_s2_valid;

    // ---- stage 1: priority checks and source select
    always_comb begin
        have_cmd   = i_item.flags[FL_HAVE_CMD];
        cmd_ok     = i_item.flags[FL_CMD_OK];
        rec_ask    = i_item.flags[FL_REC_ASK];
        have_rec   = i_item.flags[FL_HAVE_REC];
        rec_ok     = i_item.flags[FL_REC_OK];
        stop_f     = i_item.flags[FL_STOP];
        stop_stale = i_item.flags[FL_STOP_STALE];
        slow_stale = i_item.flags[FL_SLOW_STALE];
        have_dec   = i_item.flags[FL_HAVE_DEC];
        dec_stop   = i_item.flags[FL_DEC_STOP];
        have_ovr   = i_item.flags[FL_HAVE_OVR];

        rec_usable  = i_cfg.mode_bits[MD_RECOVERY] && rec_ask && have_rec && rec_ok
                      && (i_item.rec_age_ms <= i_cfg.command_timeout_ms);
        stop_active = stop_f || (have_dec && dec_stop);

        f_pick = have_ovr ? i_item.override_slowdown : i_item.decision_slowdown;
        if (have_dec && (i_item.decision_slowdown < f_pick)) begin
            f_pick = i_item.decision_slowdown;
        end
        if (f_pick > Q15_ONE) begin
            f_pick = Q15_ONE;
        end

        n_s1.kind    = KIND_PASS;
        n_s1.reason  = RSN_ALLOWED;
        n_s1.stale   = 1'b0;
        n_s1.use_rec = stop_active;
        n_s1.factor  = f_pick;
        if (stop_active) begin
            n_s1.vel = {i_item.rec_wz, i_item.rec_vy, i_item.rec_vx};
            n_s1.age = i_item.rec_age_ms;
        end else begin
            n_s1.vel = {i_item.cmd_wz, i_item.cmd_vy, i_item.cmd_vx};
            n_s1.age = i_item.cmd_age_ms;
        end

        if (!have_cmd && !rec_usable) begin
            n_s1.kind   = KIND_FORCED;
            n_s1.reason = RSN_NONE;
            n_s1.stale  = 1'b1;
        end else if (i_cfg.mode_bits[MD_FAILSAFE] && stop_stale) begin
            n_s1.kind   = KIND_FORCED;
            n_s1.reason = RSN_STOP_STALE;
            n_s1.stale  = 1'b1;
        end else if (i_cfg.mode_bits[MD_FAILSAFE] && slow_stale) begin
            n_s1.kind   = KIND_FORCED;
            n_s1.reason = RSN_SLOW_STALE;
            n_s1.stale  = 1'b1;
        end else if (stop_active && !rec_usable) begin
            n_s1.kind   = KIND_FORCED;
            n_s1.reason = RSN_STOP;
        end else if (!stop_active && !(have_cmd && cmd_ok)) begin
            // also covers a missing normal command while recovery is usable
            n_s1.kind   = KIND_FORCED;
            n_s1.reason = RSN_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
        r_s1 <= n_s1;
    end

    // ---- stage 2: age check, factor limits, pre-clamp
    always_comb begin
        cmd_stale = r_s1.age > i_cfg.command_timeout_ms;

        f_lo  = (r_s1.factor < i_cfg.slowdown_floor) ? i_cfg.slowdown_floor : r_s1.factor;
        f_hi  = (f_lo > i_cfg.slowdown_ceiling) ? i_cfg.slowdown_ceiling : f_lo;
        f_fin = (f_hi > Q15_ONE) ? Q15_ONE : f_hi;

        lim = {i_cfg.max_angular_z, i_cfg.max_linear_y, i_cfg.max_linear_x};

        n_s2.kind     = r_s1.kind;
        n_s2.reason   = r_s1.reason;
        n_s2.stale    = r_s1.stale;
        n_s2.use_rec  = r_s1.use_rec;
        n_s2.raw      = '0;
        n_s2.factor   = f_fin;
        n_s2.scale_en = {i_cfg.mode_bits[MD_SLOW_ANG], i_cfg.mode_bits[MD_SLOW_LIN],
                         i_cfg.mode_bits[MD_SLOW_LIN]};

        for (int k = 0; k < 3; k++) begin
            n_s2.neg[k] = r_s1.vel[k][15];
            abs_v[k]    = r_s1.vel[k][15] ? (~r_s1.vel[k] + 16'd1) : r_s1.vel[k];
            n_s2.mag[k] = (abs_v[k] > {1'b0, lim[k]}) ? lim[k] : abs_v[k][14:0];
        end

        if ((r_s1.kind == KIND_PASS) && cmd_stale) begin
            n_s2.reason = RSN_CMD_STALE;
            n_s2.stale  = 1'b1;
            if (i_cfg.mode_bits[MD_ZERO]) begin
                n_s2.kind = KIND_FORCED;
            end else begin
                n_s2.kind = KIND_RAW;
                n_s2.raw  = r_s1.vel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2 <= n_s2;
    end

    assign o_valid = r_s2_valid;
    assign o_s2    = r_s2;

endmodule

// ----- rtl/core/vcsg_scale.sv -----
// Q15 scaling lanes and result assembly (two stages, last one is the output register).
module vcsg_scale import vcsg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_s2       i_s2,
    output logic      o_valid,
    output t_out_beat o_result
);

    logic [2:0][30:0] prod;
    t_s3              n_s3, r_s3;
    logic             r_s3_valid;

    logic [2:0][15:0] vel;
    logic             mag_zero, raw_zero;
    t_out_beat        n_out, r_out;
    logic             r_out_valid;

    // ---- stage 3: one 15x16 multiply per lane, truncated magnitude
    always_comb begin
        n_s3.kind    = i_s2.kind;
        n_s3.reason  = i_s2.reason;
        n_s3.stale   = i_s2.stale;
        n_s3.use_rec = i_s2.use_rec;
        n_s3.raw     = i_s2.raw;
        n_s3.neg     = i_s2.neg;
        n_s3.factor  = i_s2.factor;
        for (int k = 0; k < 3; k++) begin
            prod[k] = {16'd0, i_s2.mag[k]} * {15'd0, i_s2.factor};
            // factor <= 1.0, so the scaled value never exceeds the clamped one
            n_s3.mag[k] = i_s2.scale_en[k] ? prod[k][29:15] : i_s2.mag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_valid;
        end
        r_s3 <= n_s3;
    end

    // ---- stage 4: sign restore and result beat
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vel[k] = r_s3.neg[k] ? (~{1'b0, r_s3.mag[k]} + 16'd1) : {1'b0, r_s3.mag[k]};
        end
        mag_zero = (r_s3.mag == '0);
        raw_zero = (r_s3.raw == '0);

        n_out.out_vx        = '0;
        n_out.out_vy        = '0;
        n_out.out_wz        = '0;
        n_out.allowed       = 1'b0;
        n_out.stopped       = 1'b1;
        n_out.stale_flag    = r_s3.stale;
        n_out.slow_factor   = '0;
        n_out.reason_code   = r_s3.reason;
        n_out.from_recovery = 1'b0;

        case (r_s3.kind)
            KIND_FORCED: begin
            end
            KIND_RAW: begin
                n_out.out_vx  = r_s3.raw[0];
                n_out.out_vy  = r_s3.raw[1];
                n_out.out_wz  = r_s3.raw[2];
                n_out.stopped = raw_zero;
            end
            KIND_PASS: begin
                n_out.out_vx        = vel[0];
                n_out.out_vy        = vel[1];
                n_out.out_wz        = vel[2];
                n_out.allowed       = 1'b1;
                n_out.stopped       = mag_zero;
                n_out.slow_factor   = r_s3.factor;
                n_out.from_recovery = r_s3.use_rec;
                if (mag_zero && (r_s3.factor == '0)) begin
                    n_out.reason_code = RSN_SLOW_ZERO;
                end else if (r_s3.use_rec) begin
                    n_out.reason_code = RSN_RECOVERY;
                end else begin
                    n_out.reason_code = RSN_ALLOWED;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s3_valid;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- rtl/core/velocity_command_safety_gate_unit.sv -----
// Top level of the velocity command safety gate: config registers and the pipeline.
//
//  channel   | direction | handshake                  | beat
//  ----------+-----------+----------------------------+--------------------------------
//  command   | in        | start, busy                | i_item (t_in_beat)
//  result    | out       | o_result_strobe            | o_result (t_out_beat)
//  config    | in        | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  One command beat per cycle; busy stays low. Four register stages: select,
//  limit/pre-clamp, multiply, output. A result strobes once its start has passed
//  all four; the per-lane 15x16 multiply sets the stage boundary.
//  Synchronous active-low reset clears all stage valid bits and loads the
//  register defaults. The result side has no stall, so nothing ever backs up.
module velocity_command_safety_gate_unit import vcsg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_beat    i_item,
    output logic        o_result_strobe,
    output t_out_beat   o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "velocity_command_safety_gate_unit_assert.svh"

    t_cfg r_cfg;
    logic accept;
    logic s2_valid;
    t_s2  s2;
    logic rs_allowed;
    logic rs_refused;
    logic rs_from_rec;
    logic rs_rec_reason;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_linear_x       <= 15'h7fff;
            r_cfg.max_linear_y       <= 15'h7fff;
            r_cfg.max_angular_z      <= 15'h7fff;
            r_cfg.slowdown_floor     <= 16'd0;
            r_cfg.slowdown_ceiling   <= Q15_ONE;
            r_cfg.command_timeout_ms <= 16'd500;
            r_cfg.mode_bits          <= 5'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_LINEAR_X:       r_cfg.max_linear_x       <= i_cfg_data[14:0];
                CFG_MAX_LINEAR_Y:       r_cfg.max_linear_y       <= i_cfg_data[14:0];
                CFG_MAX_ANGULAR_Z:      r_cfg.max_angular_z      <= i_cfg_data[14:0];
                CFG_SLOWDOWN_FLOOR:     r_cfg.slowdown_floor     <= i_cfg_data;
                CFG_SLOWDOWN_CEILING:   r_cfg.slowdown_ceiling   <= i_cfg_data;
                CFG_COMMAND_TIMEOUT_MS: r_cfg.command_timeout_ms <= i_cfg_data;
                CFG_MODE_BITS:          r_cfg.mode_bits          <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    vcsg_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (s2_valid),
        .o_s2    (s2)
    );

    vcsg_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s2_valid),
        .i_s2     (s2),
        .o_valid  (o_result_strobe),
        .o_result (o_result)
    );

    assign rs_allowed    = o_result_strobe && o_result.allowed;
    assign rs_refused    = o_result_strobe && !o_result.allowed;
    assign rs_from_rec   = o_result_strobe && o_result.from_recovery;
    assign rs_rec_reason = (o_result.reason_code == RSN_RECOVERY)
                           || (o_result.reason_code == RSN_SLOW_ZERO);

    // every accepted beat comes out once it has passed the four register stages
    `VCSG_ASSERT_IMP(a_latency, i_clk, i_rst_n, accept, ##4 o_result_strobe)
    // a refused beat reports no slowdown factor
    `VCSG_ASSERT_IMP(a_slow_zero, i_clk, i_rst_n, rs_refused, o_result.slow_factor == 16'd0)
    // recovery source only on an allowed beat with a recovery or zero-factor reason
    `VCSG_ASSERT_IMP(a_from_rec, i_clk, i_rst_n, rs_from_rec, o_result.allowed && rs_rec_reason)
    // an allowed beat is never flagged stale
    `VCSG_ASSERT_NEVER(a_allowed_fresh, i_clk, i_rst_n, rs_allowed && o_result.stale_flag)

endmodule
